[rtl/pdc_pkg.sv]
`default_nettype none
package pdc_pkg;

	// Field and register widths.
	localparam int MeasW  = 16;
	localparam int TargW  = 15;
	localparam int DtW    = 16;
	localparam int PulseW = 12;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 27;

	// Shared multiplier operands and product, all two's complement.
	localparam int MulAW  = 35;
	localparam int MulBW  = 28;
	localparam int ProdW  = MulAW + MulBW;

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		REG_KP      = 3'd0,
		REG_KI      = 3'd1,
		REG_KD      = 3'd2,
		REG_ILIM    = 3'd3,
		REG_OLIM    = 3'd4,
		REG_NEUTRAL = 3'd5
	} reg_idx_t;

endpackage
`default_nettype wire

[rtl/pdc_if.sv]
`default_nettype none
interface pdc_in_if
	import pdc_pkg::*;
	();
	logic                    valid;
	logic                    ready;
	logic signed [MeasW-1:0] measured_depth;
	logic        [TargW-1:0] target_depth;
	logic        [DtW-1:0]   elapsed_ms;
	logic                    clear_integral;

	modport source (output valid, measured_depth, target_depth, elapsed_ms, clear_integral,
		input ready);
	modport sink (input valid, measured_depth, target_depth, elapsed_ms, clear_integral,
		output ready);
endinterface

interface pdc_out_if
	import pdc_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [PulseW-1:0] servo_pulse;
	logic              saturated;

	modport source (output valid, servo_pulse, saturated, input ready);
	modport sink (input valid, servo_pulse, saturated, output ready);
endinterface
`default_nettype wire

[rtl/pdc_mul.sv]
`default_nettype none
module pdc_mul
	import pdc_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic signed [MulAW-1:0] a,
	input  wire logic signed [MulBW-1:0] b,
	output logic signed [ProdW-1:0]      prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule
`default_nettype wire

[rtl/pid_depth_controller.sv]
// An accepted transaction runs through nine passes of the shared multiplier (issue plus
// write-back each), a clamp of the integral and a 10-step restoring divider before its result is valid.
// A new transaction is accepted only while idle; one with zero elapsed time is accepted and
// gives no result. A finished result waits in the output register.
// Reset: asynchronous, active low; registers return to their defaults, integral and previous
// error clear to zero.
`default_nettype none
module pid_depth_controller
	import pdc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_wdata,
	pdc_in_if.sink                   cmd,
	pdc_out_if.source                result
);

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_WB, S_CLAMP, S_DCHK, S_OVF, S_DIV, S_OUT
	} state_t;

	typedef enum logic [3:0] {
		ST_ED, ST_DTK, ST_KPE, ST_N1, ST_KIDT, ST_N2, ST_KDDE, ST_N3, ST_DEN
	} step_t;

	state_t state_q;
	step_t  step_q;

	logic [15:0] kp_q, ki_q, kd_q;
	logic [26:0] ilim_q;
	logic [8:0]  olim_q;
	logic [10:0] neutral_q;

	logic signed [16:0] err_q, prev_q;
	logic signed [17:0] de_q;
	logic signed [27:0] integ_q;
	logic signed [33:0] isum_q;
	logic [DtW-1:0]     dt_q;
	logic               clr_q;
	logic [25:0]        dtk_q;
	logic signed [MulAW-1:0] t_q;
	logic signed [ProdW-1:0] acc_q;
	logic [43:0] den_q;
	logic [61:0] nabs_q;
	logic [53:0] rem_q;
	logic [52:0] dsh_q;
	logic [9:0]  quo_q;
	logic [3:0]  cnt_q;
	logic        neg_q, big_q;

	logic              rsp_valid_q;
	logic [PulseW-1:0] pulse_q;
	logic              sat_q;

	logic signed [MulAW-1:0] mul_a;
	logic signed [MulBW-1:0] mul_b;
	logic signed [ProdW-1:0] prod_q;

	logic accept;
	logic out_load;
	logic signed [16:0] err_new;
	logic [9:0]  mag;
	logic        sat_new;
	logic [8:0]  cmag;
	logic signed [12:0] pulse_s;
	logic [53:0] rem_sub;
	logic        rem_ge;

	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign out_load  = (state_q == S_OUT) && (!rsp_valid_q || result.ready);
	assign err_new   = $signed({2'b00, cmd.target_depth})
		- $signed({cmd.measured_depth[MeasW-1], cmd.measured_depth});

	assign result.valid       = rsp_valid_q;
	assign result.servo_pulse = pulse_q;
	assign result.saturated   = sat_q;

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (step_q)
			ST_ED: begin
				mul_a = MulAW'(err_q);
				mul_b = $signed(MulBW'(dt_q));
			end
			ST_DTK: begin
				mul_a = $signed(MulAW'(dt_q));
				mul_b = MulBW'(1000);
			end
			ST_KPE: begin
				mul_a = $signed(MulAW'(kp_q));
				mul_b = MulBW'(err_q);
			end
			ST_N1: begin
				mul_a = t_q;
				mul_b = $signed(MulBW'(dtk_q));
			end
			ST_KIDT: begin
				mul_a = $signed(MulAW'(ki_q));
				mul_b = $signed(MulBW'(dt_q));
			end
			ST_N2: begin
				mul_a = t_q;
				mul_b = integ_q;
			end
			ST_KDDE: begin
				mul_a = $signed(MulAW'(kd_q));
				mul_b = MulBW'(de_q);
			end
			ST_N3: begin
				mul_a = t_q;
				mul_b = MulBW'(1000000);
			end
			ST_DEN: begin
				mul_a = $signed(MulAW'(dt_q));
				mul_b = MulBW'(15625);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	pdc_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// Restoring division step and output shaping.
	assign rem_ge  = rem_q >= {1'b0, dsh_q};
	assign rem_sub = rem_q - {1'b0, dsh_q};

	always_comb begin
		mag     = big_q ? 10'h3FF : quo_q;
		sat_new = big_q || (mag > {1'b0, olim_q});
		cmag    = sat_new ? olim_q : mag[8:0];
		if (neg_q) begin
			pulse_s = $signed({2'b00, neutral_q}) - $signed({4'b0000, cmag});
		end else begin
			pulse_s = $signed({2'b00, neutral_q}) + $signed({4'b0000, cmag});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= ST_ED;
			kp_q        <= 16'd10240;
			ki_q        <= 16'd1280;
			kd_q        <= 16'd3840;
			ilim_q      <= 27'd20000000;
			olim_q      <= 9'd400;
			neutral_q   <= 11'd1500;
			integ_q     <= '0;
			prev_q      <= '0;
			err_q       <= '0;
			de_q        <= '0;
			isum_q      <= '0;
			dt_q        <= '0;
			clr_q       <= 1'b0;
			dtk_q       <= '0;
			t_q         <= '0;
			acc_q       <= '0;
			den_q       <= '0;
			nabs_q      <= '0;
			rem_q       <= '0;
			dsh_q       <= '0;
			quo_q       <= '0;
			cnt_q       <= '0;
			neg_q       <= 1'b0;
			big_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			pulse_q     <= '0;
			sat_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_KP:      kp_q      <= cfg_wdata[15:0];
					REG_KI:      ki_q      <= cfg_wdata[15:0];
					REG_KD:      kd_q      <= cfg_wdata[15:0];
					REG_ILIM:    ilim_q    <= cfg_wdata[26:0];
					REG_OLIM:    olim_q    <= cfg_wdata[8:0];
					REG_NEUTRAL: neutral_q <= cfg_wdata[10:0];
					default: ;
				endcase
			end

			rsp_valid_q <= out_load || (rsp_valid_q && !result.ready);

			unique case (state_q)
				S_IDLE: begin
					// A transaction with zero elapsed time leaves all state untouched.
					if (accept && (cmd.elapsed_ms != '0)) begin
						err_q   <= err_new;
						dt_q    <= cmd.elapsed_ms;
						clr_q   <= cmd.clear_integral;
						step_q  <= ST_ED;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_WB;
				end
				S_WB: begin
					state_q <= (step_q == ST_ED) ? S_CLAMP :
						(step_q == ST_DEN) ? S_DCHK : S_MUL;
					step_q  <= step_t'(step_q + 4'd1);
					unique case (step_q)
						ST_ED:   isum_q <= (clr_q ? 34'sd0 : 34'(integ_q))
							+ 34'($signed(prod_q[32:0]));
						ST_DTK:  dtk_q <= prod_q[25:0];
						ST_KPE:  t_q   <= prod_q[MulAW-1:0];
						ST_N1:   acc_q <= prod_q;
						ST_KIDT: t_q   <= prod_q[MulAW-1:0];
						ST_N2:   acc_q <= acc_q + prod_q;
						ST_KDDE: t_q   <= prod_q[MulAW-1:0];
						ST_N3:   acc_q <= acc_q + prod_q;
						ST_DEN:  den_q <= {prod_q[29:0], 14'd0};
						default: ;
					endcase
				end
				S_CLAMP: begin
					if (isum_q > $signed({7'd0, ilim_q})) begin
						integ_q <= $signed({1'b0, ilim_q});
					end else if (isum_q < -$signed({7'd0, ilim_q})) begin
						integ_q <= -$signed({1'b0, ilim_q});
					end else begin
						integ_q <= isum_q[27:0];
					end
					de_q    <= 18'(err_q) - 18'(prev_q);
					prev_q  <= err_q;
					state_q <= S_MUL;
				end
				S_DCHK: begin
					neg_q   <= acc_q[ProdW-1];
					nabs_q  <= acc_q[ProdW-1] ? 62'(-acc_q) : acc_q[61:0];
					dsh_q   <= {den_q, 9'd0};
					state_q <= S_OVF;
				end
				S_OVF: begin
					// A quotient of 1024 or more saturates for any output limit.
					big_q   <= nabs_q >= {8'd0, den_q, 10'd0};
					rem_q   <= nabs_q[53:0];
					quo_q   <= '0;
					cnt_q   <= 4'd9;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (rem_ge) begin
						rem_q <= rem_sub;
					end
					quo_q <= {quo_q[8:0], rem_ge};
					dsh_q <= dsh_q >> 1;
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd0) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						sat_q   <= sat_new;
						pulse_q <= pulse_s[12] ? '0 : pulse_s[PulseW-1:0];
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
